// ===== sv/oewn_pkg.sv =====
package oewn_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] POS_LIMIT = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_CHANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SWAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_LENGTH = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_CHANGE = 3'd1,
        KIND_SWAP   = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_DELETE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_COLLECT = 2'd0,
        S_PLAN    = 2'd1,
        S_WALK    = 2'd2,
        S_RESULT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] char_first;
        logic [CHAR_W-1:0] char_second;
        logic              last_position;
    } t_in_word;

    typedef struct packed {
        logic              is_neighbor;
        logic [KIND_W-1:0] edit_kind;
        logic [LEN_W-1:0]  diff_position;
        logic [CHAR_W-1:0] edit_char;
        logic              word_overflow;
    } t_out_word;

endpackage

// ===== sv/one_edit_word_neighbor_check.sv =====
// Flow: a word pair is collected position by position; after the last position the
// block passes through a plan state, a walk over W positions (W = the common length,
// or shorter + 1; skipped when no edit can match) and a result state that shows the result word.
// Throughput: one position per cycle in the collect state; the block takes no positions in the other states,
// and the walk reads both character stores one position per cycle through one compare unit.
// Reset (synchronous, active low) clears control and counters; stores are not cleared.
module one_edit_word_neighbor_check
    import oewn_pkg::*;
#(
    parameter int unsigned MAX_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data
);

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

    logic [CHAR_W-1:0] r_store_a [MAX_LEN];
    logic [CHAR_W-1:0] r_store_b [MAX_LEN];

    t_state r_state, n_state;

    logic r_allow_change, r_allow_swap, r_allow_length;

    logic [LEN_W-1:0] r_pos_cnt, r_len_a, r_len_b;
    logic             r_overflow;

    // walk control
    logic [LEN_W-1:0] r_idx, r_walk_len, r_rd_idx;
    logic             r_rd_vld;
    logic             r_eq, r_ins, r_skip;
    logic [CHAR_W-1:0] r_ra0, r_ra1, r_rb0, r_rb1;

    // walk results
    logic [1:0]        r_cnt;
    logic              r_swap_ok, r_div, r_fail;
    logic [LEN_W-1:0]  r_pos;
    logic [CHAR_W-1:0] r_ch;

    t_out_word r_out;
    logic      r_out_valid;

    logic in_acc, take_a, take_b, ovf_a, ovf_b, walk_last, out_load;
    logic [AW-1:0] wr_addr, rd_addr, rd_addr1;
    logic [LEN_W-1:0] mn_len;
    logic plan_skip;
    t_kind res_kind;

    assign in_acc  = i_in_valid && o_in_ready;
    assign wr_addr = r_pos_cnt[AW-1:0];
    assign take_a  = (i_in_data.char_first  != '0) && (r_len_a == r_pos_cnt);
    assign take_b  = (i_in_data.char_second != '0) && (r_len_b == r_pos_cnt);
    assign ovf_a   = take_a && (r_pos_cnt >= MAX_LEN_L);
    assign ovf_b   = take_b && (r_pos_cnt >= MAX_LEN_L);

    assign rd_addr  = r_idx[AW-1:0];
    assign rd_addr1 = rd_addr + AW'(1);
    assign mn_len   = (r_len_a < r_len_b) ? r_len_a : r_len_b;
    assign walk_last = r_rd_vld && (r_rd_idx == r_walk_len - LEN_W'(1));

    always_comb begin
        plan_skip = r_overflow;
        if (r_len_a == r_len_b) begin
            if (!(r_allow_change || r_allow_swap) || r_len_a == '0) begin
                plan_skip = 1'b1;
            end
        end else if (!r_allow_length || !((r_len_a + LEN_W'(1) == r_len_b) ||
                                          (r_len_b + LEN_W'(1) == r_len_a))) begin
            plan_skip = 1'b1;
        end
    end

    always_comb begin
        res_kind = KIND_NONE;
        if (!r_skip) begin
            if (r_eq) begin
                if (r_cnt == 2'd1 && r_allow_change) begin
                    res_kind = KIND_CHANGE;
                end else if (r_cnt == 2'd2 && r_allow_swap && r_swap_ok) begin
                    res_kind = KIND_SWAP;
                end
            end else if (!r_fail) begin
                res_kind = r_ins ? KIND_INSERT : KIND_DELETE;
            end
        end
    end

    assign out_load = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready = 1'b1;
                if (in_acc && i_in_data.last_position) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = plan_skip ? S_RESULT : S_WALK;
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    // character stores: one write port, two read ports with registered data
    always_ff @(posedge i_clk) begin
        if (in_acc && take_a && !ovf_a) begin
            r_store_a[wr_addr] <= i_in_data.char_first;
        end
        if (in_acc && take_b && !ovf_b) begin
            r_store_b[wr_addr] <= i_in_data.char_second;
        end
        r_ra0 <= r_store_a[rd_addr];
        r_ra1 <= r_store_a[rd_addr1];
        r_rb0 <= r_store_b[rd_addr];
        r_rb1 <= r_store_b[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_change <= 1'b0;
            r_allow_swap   <= 1'b0;
            r_allow_length <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALLOW_CHANGE: r_allow_change <= i_cfg_data;
                CFG_ALLOW_SWAP:   r_allow_swap   <= i_cfg_data;
                CFG_ALLOW_LENGTH: r_allow_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position and length tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_cnt  <= '0;
            r_len_a    <= '0;
            r_len_b    <= '0;
            r_overflow <= 1'b0;
        end else if (in_acc) begin
            if (take_a && !ovf_a) begin
                r_len_a <= r_pos_cnt + LEN_W'(1);
            end
            if (take_b && !ovf_b) begin
                r_len_b <= r_pos_cnt + LEN_W'(1);
            end
            if (ovf_a || ovf_b) begin
                r_overflow <= 1'b1;
            end
            if (r_pos_cnt != POS_LIMIT) begin
                r_pos_cnt <= r_pos_cnt + LEN_W'(1);
            end
        end else if (out_load) begin
            r_pos_cnt  <= '0;
            r_len_a    <= '0;
            r_len_b    <= '0;
            r_overflow <= 1'b0;
        end
    end

    // walk sequencer and shared compare unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else if (r_state == S_WALK && r_idx < r_walk_len) begin
            r_rd_vld <= 1'b1;
            r_rd_idx <= r_idx;
            r_idx    <= r_idx + LEN_W'(1);
        end else begin
            r_rd_vld <= 1'b0;
            if (r_state == S_PLAN) begin
                r_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PLAN) begin
            r_eq       <= (r_len_a == r_len_b);
            r_ins      <= (r_len_a < r_len_b);
            r_skip     <= plan_skip;
            r_walk_len <= (r_len_a == r_len_b) ? r_len_a : mn_len + LEN_W'(1);
            r_cnt      <= '0;
            r_swap_ok  <= 1'b0;
            r_div      <= 1'b0;
            r_fail     <= 1'b0;
            r_pos      <= '0;
            r_ch       <= '0;
        end else if (r_state == S_WALK && r_rd_vld) begin
            if (r_eq) begin
                if (r_ra0 != r_rb0) begin
                    if (r_cnt == 2'd0) begin
                        r_pos     <= r_rd_idx;
                        r_ch      <= r_rb0;
                        r_swap_ok <= (r_rd_idx + LEN_W'(1) < r_len_a) &&
                                     (r_ra0 == r_rb1) && (r_rb0 == r_ra1);
                    end
                    if (r_cnt != 2'd3) begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
            end else if (walk_last) begin
                // no difference in the common part: edit sits at the end
                if (!r_div) begin
                    r_pos <= r_rd_idx;
                    r_ch  <= r_ins ? r_rb0 : '0;
                end
            end else begin
                if (!r_div && r_ra0 != r_rb0) begin
                    r_div <= 1'b1;
                    r_pos <= r_rd_idx;
                    r_ch  <= r_ins ? r_rb0 : '0;
                end
                if ((r_div || r_ra0 != r_rb0) &&
                    !(r_ins ? (r_ra0 == r_rb1) : (r_ra1 == r_rb0))) begin
                    r_fail <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.is_neighbor   <= (res_kind != KIND_NONE);
            r_out.edit_kind     <= res_kind;
            r_out.diff_position <= (res_kind != KIND_NONE) ? r_pos : '0;
            r_out.edit_char     <= (res_kind == KIND_CHANGE || res_kind == KIND_INSERT) ?
                                   r_ch : '0;
            r_out.word_overflow <= r_overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_walk_len))
        else $error("walk index ran past walk length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= MAX_LEN_L) && (r_len_b <= MAX_LEN_L))
        else $error("word length beyond store depth");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result word shown outside result state");

    a_neighbor_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_neighbor == (o_out_data.edit_kind != KIND_NONE)))
        else $error("neighbor flag disagrees with edit kind");

    a_overflow_no: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.word_overflow) |-> !o_out_data.is_neighbor)
        else $error("overflowed word reported as neighbor");

endmodule

// ===== bench/one_edit_word_neighbor_check_test.sv =====
`timescale 1ns / 1ps

module one_edit_word_neighbor_check_test;
    import oewn_pkg::*;

    localparam int WORD_MAX    = 32;
    localparam int WORD_BUF    = 48;
    localparam int SETTLE      = WORD_MAX + 4;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 800;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef enum int {
        MUT_SAME,
        MUT_CHANGE,
        MUT_SWAP,
        MUT_INSERT,
        MUT_DELETE,
        MUT_TWO_CHANGES,
        MUT_FRESH,
        MUT_SWAP_CHANGE,
        MUT_DOUBLE_INSERT
    } t_mutation;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic                 cfg_data  = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_word             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_data;

    // predictor state
    logic [7:0]  first_store  [WORD_MAX];
    logic [7:0]  second_store [WORD_MAX];
    int unsigned pos_cnt    = 0;
    int unsigned len_first  = 0;
    int unsigned len_second = 0;
    bit          ovf_seen   = 1'b0;
    bit          en_change  = 1'b0;
    bit          en_swap    = 1'b0;
    bit          en_length  = 1'b0;
    t_out_word   expected_q[$];

    // word pair under construction
    logic [7:0] wa [WORD_BUF];
    logic [7:0] wb [WORD_BUF];

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int items_sent  = 0;
    int fail_count  = 0;
    int idle_cycles = 0;

    one_edit_word_neighbor_check #(
        .MAX_LEN(WORD_MAX)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait(input bit on);
        return on ? int'($urandom_range(0, 13)) : 0;
    endfunction

    function automatic logic [7:0] rand_char(input bit narrow);
        return narrow ? 8'($urandom_range(97, 100)) : 8'($urandom_range(1, 255));
    endfunction

    // a word ends at its first zero; nothing is stored past WORD_MAX
    function automatic void absorb_char(input bit to_second, input logic [7:0] ch);
        if (ch == 8'd0) return;
        if ((to_second ? len_second : len_first) != pos_cnt) return;
        if (pos_cnt >= WORD_MAX) begin
            ovf_seen = 1'b1;
            return;
        end
        if (to_second) begin
            second_store[pos_cnt] = ch;
            len_second = pos_cnt + 1;
        end else begin
            first_store[pos_cnt] = ch;
            len_first = pos_cnt + 1;
        end
    endfunction

    function automatic t_out_word judge_pair();
        t_out_word   r;
        int unsigned la, lb, cnt, fd, mn, i, p;
        r = '0;
        la = len_first;
        lb = len_second;
        r.word_overflow = ovf_seen;
        if (ovf_seen) return r;
        if (la == lb) begin
            if (en_change || en_swap) begin
                cnt = 0;
                fd = 0;
                for (i = 0; i < la; i++) begin
                    if (first_store[i] != second_store[i]) begin
                        if (cnt == 0) fd = i;
                        cnt++;
                    end
                end
                if (cnt == 1 && en_change) begin
                    r.edit_kind     = KIND_CHANGE;
                    r.diff_position = fd[LEN_W-1:0];
                    r.edit_char     = second_store[fd];
                end else if (cnt == 2 && en_swap && fd + 1 < la
                             && first_store[fd] == second_store[fd + 1]
                             && second_store[fd] == first_store[fd + 1]) begin
                    r.edit_kind     = KIND_SWAP;
                    r.diff_position = fd[LEN_W-1:0];
                end
            end
        end else if (en_length && (la + 1 == lb || lb + 1 == la)) begin
            mn = (la < lb) ? la : lb;
            i = 0;
            while (i < mn && first_store[i] == second_store[i]) i++;
            p = i;
            // the rest must line up with a shift of one
            if (la < lb) begin
                while (i < la && first_store[i] == second_store[i + 1]) i++;
            end else begin
                while (i < lb && first_store[i + 1] == second_store[i]) i++;
            end
            if (i == mn) begin
                r.diff_position = p[LEN_W-1:0];
                if (la < lb) begin
                    r.edit_kind = KIND_INSERT;
                    r.edit_char = second_store[p];
                end else begin
                    r.edit_kind = KIND_DELETE;
                end
            end
        end
        r.is_neighbor = (r.edit_kind != KIND_NONE);
        return r;
    endfunction

    task automatic send_word(input t_in_word w);
        int        gap;
        t_out_word exp_word;
        gap = draw_wait(in_idle_on);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        absorb_char(1'b0, w.char_first);
        absorb_char(1'b1, w.char_second);
        if (pos_cnt < POS_LIMIT) pos_cnt++;
        if (w.last_position) begin
            exp_word   = judge_pair();
            expected_q = {expected_q, exp_word};
            pos_cnt    = 0;
            len_first  = 0;
            len_second = 0;
            ovf_seen   = 1'b0;
        end
    endtask

    // lay out wa/wb position by position; junk goes only past a word's ending zero
    task automatic send_words(input int la, input int lb, input int extra, input bit junk);
        int       n;
        t_in_word w;
        n = ((la > lb) ? la : lb) + extra;
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
            w.char_first    = (i < la) ? wa[i] : (junk && i > la) ? rand_char(1'b0) : 8'd0;
            w.char_second   = (i < lb) ? wb[i] : (junk && i > lb) ? rand_char(1'b0) : 8'd0;
            w.last_position = (i == n - 1);
            send_word(w);
        end
    endtask

    task automatic run_words(input string a, input string b);
        for (int i = 0; i < a.len(); i++) wa[i] = a[i];
        for (int i = 0; i < b.len(); i++) wb[i] = b[i];
        send_words(a.len(), b.len(), 0, 1'b0);
    endtask

    task automatic fill_random(input int len, input bit narrow);
        for (int i = 0; i < len; i++) begin
            wa[i] = rand_char(narrow);
            wb[i] = wa[i];
        end
    endtask

    task automatic apply_config(input bit ch, input bit sw, input bit ln);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_SPARE;
        cfg_data <= 1'($urandom_range(0, 1));
        @(posedge clk);
        cfg_idx  <= CFG_ALLOW_CHANGE;
        cfg_data <= ch;
        @(posedge clk);
        cfg_idx  <= CFG_ALLOW_SWAP;
        cfg_data <= sw;
        @(posedge clk);
        cfg_idx  <= CFG_ALLOW_LENGTH;
        cfg_data <= ln;
        @(posedge clk);
        cfg_we    <= 1'b0;
        en_change = ch;
        en_swap   = sw;
        en_length = ln;
    endtask

    task automatic random_pair();
        int        la, lb, p;
        bit        narrow;
        logic [7:0] tmp;
        t_mutation m;
        narrow = 1'($urandom_range(0, 1));
        la = ($urandom_range(0, 11) == 0) ? int'($urandom_range(WORD_MAX - 3, WORD_MAX + 4))
                                          : int'($urandom_range(0, 7));
        fill_random(la, narrow);
        lb = la;
        m = ($urandom_range(0, 2) != 0) ? t_mutation'($urandom_range(1, 4))
                                        : t_mutation'($urandom_range(0, 8));
        case (m)
            MUT_CHANGE, MUT_TWO_CHANGES: begin
                for (int k = 0; k < ((m == MUT_TWO_CHANGES) ? 2 : 1); k++) begin
                    if (lb > 0) wb[$urandom_range(0, lb - 1)] = rand_char(narrow);
                end
            end
            MUT_SWAP, MUT_SWAP_CHANGE: begin
                if (lb > 1) begin
                    p = $urandom_range(0, lb - 2);
                    tmp = wb[p];
                    wb[p] = wb[p + 1];
                    wb[p + 1] = tmp;
                end
                if (m == MUT_SWAP_CHANGE && lb > 0) wb[$urandom_range(0, lb - 1)] = rand_char(narrow);
            end
            MUT_INSERT, MUT_DOUBLE_INSERT: begin
                for (int k = 0; k < ((m == MUT_DOUBLE_INSERT) ? 2 : 1); k++) begin
                    p = $urandom_range(0, lb);
                    for (int i = lb; i > p; i--) wb[i] = wb[i - 1];
                    wb[p] = rand_char(narrow);
                    lb++;
                end
            end
            MUT_DELETE: begin
                if (lb > 0) begin
                    p = $urandom_range(0, lb - 1);
                    for (int i = p; i < lb - 1; i++) wb[i] = wb[i + 1];
                    lb--;
                end
            end
            MUT_FRESH: begin
                lb = $urandom_range(0, 8);
                for (int i = 0; i < lb; i++) wb[i] = rand_char(narrow);
            end
            default: ;
        endcase
        send_words(la, lb, ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 3)) : 0,
                   ($urandom_range(0, 3) == 0));
    endtask

    task automatic test_reset_defaults();
        // every edit kind starts disabled
        run_words("cat", "cot");
        run_words("cat", "act");
        run_words("cat", "cart");
        run_words("cart", "cat");
    endtask

    task automatic test_edit_kinds();
        apply_config(1'b1, 1'b1, 1'b1);
        run_words("cat", "cat");
        run_words("cat", "cot");
        run_words("cat", "act");
        run_words("abcd", "abdc");
        run_words("cat", "cast");
        run_words("cast", "cat");
        run_words("cat", "cats");
        run_words("cats", "cat");
        run_words("", "x");
        run_words("x", "");
        run_words("", "");
        run_words("abcd", "badc");
        run_words("abc", "xbz");
        run_words("ab", "cd");
        run_words("cat", "casts");
    endtask

    task automatic test_kind_enables();
        for (int c = 0; c < 4; c++) begin
            apply_config(c == 1, c == 2, c == 3);
            run_words("cat", "cot");
            run_words("cat", "act");
            run_words("cat", "cart");
            run_words("cart", "cat");
        end
    endtask

    task automatic test_extremes();
        apply_config(1'b1, 1'b1, 1'b1);
        wa[0] = 8'hFF; wa[1] = 8'h01;
        wb[0] = 8'h01; wb[1] = 8'hFF;
        send_words(2, 2, 0, 1'b0);
        wa[0] = 8'h80;
        wb[0] = 8'h7F;
        send_words(1, 1, 0, 1'b0);
        wa[0] = 8'h01;
        wb[0] = 8'hFF; wb[1] = 8'h01;
        send_words(1, 2, 0, 1'b0);
        // full-length words, difference at the last stored position
        fill_random(WORD_MAX, 1'b0);
        wa[WORD_MAX - 1] = 8'h41;
        wb[WORD_MAX - 1] = 8'hFF;
        send_words(WORD_MAX, WORD_MAX, 0, 1'b0);
        fill_random(WORD_MAX, 1'b0);
        send_words(WORD_MAX - 1, WORD_MAX, 0, 1'b0);
        // words one or more positions past the store on either side
        fill_random(WORD_MAX + 1, 1'b0);
        send_words(WORD_MAX, WORD_MAX + 1, 0, 1'b0);
        send_words(WORD_MAX + 1, WORD_MAX + 1, 0, 1'b0);
        send_words(3, WORD_MAX + 1, 0, 1'b0);
        send_words(WORD_MAX + 4, 2, 0, 1'b0);
        // characters after a word's ending zero are dropped
        run_words("ab", "abc");
        fill_random(3, 1'b1);
        send_words(2, 3, 3, 1'b1);
        // long run past the position counter's ceiling, junk past each word's ending zero
        fill_random(3, 1'b1);
        wb[1] = 8'h7A;
        send_words(3, 3, 200, 1'b1);
    endtask

    task automatic test_random_pairs();
        int target, pairs;
        for (int c = 0; c < 8; c++) begin
            apply_config(c[0], c[1], c[2]);
            target = items_sent + RANDOM_ITEMS / 8;
            pairs = 0;
            while (items_sent < target) begin
                if (pairs % 12 == 0) begin
                    in_idle_on  = 1'($urandom_range(0, 1));
                    out_idle_on = 1'($urandom_range(0, 1));
                end
                random_pair();
                pairs++;
            end
        end
    endtask

    initial begin : result_side
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(out_idle_on);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_results
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", out_data);
                fail_count++;
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                if (out_data.is_neighbor !== want.is_neighbor) begin
                    $error("is_neighbor: expected %0d, got %0d",
                           want.is_neighbor, out_data.is_neighbor);
                    fail_count++;
                end
                if (out_data.edit_kind !== want.edit_kind) begin
                    $error("edit_kind: expected %0d, got %0d", want.edit_kind, out_data.edit_kind);
                    fail_count++;
                end
                if (out_data.diff_position !== want.diff_position) begin
                    $error("diff_position: expected %0d, got %0d",
                           want.diff_position, out_data.diff_position);
                    fail_count++;
                end
                if (out_data.edit_char !== want.edit_char) begin
                    $error("edit_char: expected %0d, got %0d", want.edit_char, out_data.edit_char);
                    fail_count++;
                end
                if (out_data.word_overflow !== want.word_overflow) begin
                    $error("word_overflow: expected %0d, got %0d",
                           want.word_overflow, out_data.word_overflow);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_edit_kinds();
        test_kind_enables();
        test_extremes();
        test_random_pairs();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/oewn_pkg.sv
sv/one_edit_word_neighbor_check.sv
bench/one_edit_word_neighbor_check_test.sv
